@@ rtl/core/cbs_pkg.sv @@
package cbs_pkg;

    // register map
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd2;
    localparam logic [2:0] REG_OFFSET_X     = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int DIM_W       = 13;   // image_width / image_height
    localparam int CNT_W       = 12;   // sample_count
    localparam int OFS_W       = 12;   // offset_x / offset_y
    localparam int PT_W        = 13;   // point_x / point_y

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CNT_W-1:0] RST_SAMPLE_COUNT = 12'd100;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // first sampled column, edge margins and band limits
    localparam int FIRST_COL   = 4;
    localparam int EDGE_MARGIN = 4;
    localparam int BAND1_START = 5;
    localparam int BOTTOM_GAP  = 5;

    localparam logic [1:0] BAND_UPPER_FIRST = 2'd0;
    localparam logic [1:0] BAND_UPPER_LAST  = 2'd1;
    localparam logic [1:0] BAND_LOWER_FIRST = 2'd2;
    localparam logic [1:0] BAND_LOWER_LAST  = 2'd3;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_COUNT = 1'b1;

endpackage

@@ rtl/core/cbs_step_div.sv @@
module cbs_step_div
    import cbs_pkg::*;
#(
    parameter int W = 13
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  div_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;

    logic [W:0]   rem_sh;
    logic [W+1:0] diff;

    // restoring division, one quotient bit a cycle
    always_comb begin
        rem_sh    = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[W+1]) begin
                rem_next = diff[W:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/column_boundary_sampler.sv @@
// Column boundary sampler. Marker pixels arrive column by column, one flag per
// transfer, and are taken at one pixel per clock. Columns 4, 4+step, ... below
// width-4 are sampled, four boundary bands are tracked in each, and at the
// column's last row four points (bands 0..3) leave on the m_ channel, one per
// clock while m_ready is high. The step (width-9)/(count-1) is worked out by a
// bit-serial divider after reset and after every configuration write; while it
// runs s_ready is low. Width, height and count take effect at the next frame
// start, the offsets at once. Apart from the divider, the input only stalls at a
// column or frame end that has a result to send while earlier results are still
// going out. A sample count below 2 or not below width-8 gives no points;
// instead a single result with status 1 is sent at the last pixel of the frame.
module column_boundary_sampler
    import cbs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_is_boundary,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_band,
    output logic [PT_W-1:0]        m_point_x,
    output logic [PT_W-1:0]        m_point_y,
    output logic                   m_found,
    output logic                   m_last_in_column,
    output logic                   m_status
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int NW = WW + 1;     // next sampled column, saturating
    localparam int CX = WW + 2;
    localparam int HX = HW + 3;

    // configuration registers
    logic [DIM_W-1:0] image_width_reg, image_height_reg;
    logic [CNT_W-1:0] sample_count_reg;
    logic [OFS_W-1:0] offset_x_reg, offset_y_reg;
    logic             start_reg;

    // frame state
    logic [WW-1:0] frame_w_reg;
    logic [HW-1:0] frame_h_reg;
    logic          frame_ok_reg;
    logic [WW-1:0] step_reg;
    logic [NW-1:0] nsc_reg;
    logic [HW-1:0] row_reg;
    logic [WW-1:0] col_reg;
    logic [HW-1:0] band_row_reg [4];
    logic          band_found_reg [4];

    // result buffer
    logic            out_valid_reg;
    logic [1:0]      out_idx_reg;
    logic            out_err_reg;
    logic [PT_W-1:0] out_x_reg;
    logic [PT_W-1:0] out_y_reg [4];
    logic            out_found_reg [4];

    logic          cfg_xfer, s_xfer, m_xfer;
    logic          div_busy;
    logic [WW-1:0] div_quo;
    logic [WW-1:0] w_cl;
    logic [HW-1:0] h_cl;
    logic          ok_cfg;

    logic          frame_start;
    logic [WW-1:0] cur_w;
    logic [HW-1:0] cur_h;
    logic          cur_ok;
    logic [WW-1:0] cur_step;
    logic [NW-1:0] cur_nsc;
    logic [HW-1:0] cur_row [4];
    logic          cur_found [4];
    logic [HW-1:0] nxt_row [4];
    logic          nxt_found [4];

    logic [HX-1:0] r_x, h_x, h2_x;
    logic          sampled, col_end, frame_end, emit, out_free;
    logic [NW:0]   nsc_sum;
    logic [NW-1:0] nsc_adv;
    logic [PT_W-1:0] fb_y [4];

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            sample_count_reg <= RST_SAMPLE_COUNT;
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
            start_reg        <= 1'b1;
        end else begin
            start_reg <= cfg_xfer;
            if (cfg_xfer) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                    REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[CNT_W-1:0];
                    REG_OFFSET_X:     offset_x_reg     <= cfg_data[OFS_W-1:0];
                    REG_OFFSET_Y:     offset_y_reg     <= cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // clamped geometry and count check from the live registers
    always_comb begin
        if (image_width_reg == '0) begin
            w_cl = WW'(1);
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            w_cl = WW'(MAX_WIDTH);
        end else begin
            w_cl = WW'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_cl = HW'(1);
        end else if (32'(image_height_reg) > 32'(MAX_HEIGHT)) begin
            h_cl = HW'(MAX_HEIGHT);
        end else begin
            h_cl = HW'(image_height_reg);
        end
        ok_cfg = (sample_count_reg >= CNT_W'(2))
              && (32'(sample_count_reg) + 32'd8 < 32'(w_cl));
    end

    cbs_step_div #(
        .W (WW)
    ) u_step_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (WW'(w_cl - WW'(9))),
        .divisor  (WW'(sample_count_reg - CNT_W'(1))),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign frame_start = (row_reg == '0) && (col_reg == '0);

    always_comb begin
        cur_w    = frame_start ? w_cl   : frame_w_reg;
        cur_h    = frame_start ? h_cl   : frame_h_reg;
        cur_ok   = frame_start ? ok_cfg : frame_ok_reg;
        cur_step = frame_start ? (ok_cfg ? div_quo : '0) : step_reg;
        cur_nsc  = frame_start ? NW'(FIRST_COL) : nsc_reg;
        for (int k = 0; k < 4; k++) begin
            cur_row[k]   = frame_start ? '0   : band_row_reg[k];
            cur_found[k] = frame_start ? 1'b0 : band_found_reg[k];
        end

        r_x  = HX'(row_reg);
        h_x  = HX'(cur_h);
        h2_x = HX'(cur_h >> 1);

        sampled   = cur_ok && (NW'(col_reg) == cur_nsc)
                 && (CX'(col_reg) + CX'(EDGE_MARGIN) < CX'(cur_w));
        col_end   = (r_x + HX'(1) >= h_x);
        frame_end = (CX'(col_reg) + CX'(1) >= CX'(cur_w));
        emit      = col_end && (sampled || (frame_end && !cur_ok));

        // band tracking: first hit keeps the earliest row, last hit the latest
        for (int k = 0; k < 4; k++) begin
            nxt_row[k]   = cur_row[k];
            nxt_found[k] = cur_found[k];
        end
        if (sampled && s_is_boundary) begin
            if (!cur_found[0] && r_x >= HX'(FIRST_COL) && r_x < h2_x) begin
                nxt_row[0]   = row_reg;
                nxt_found[0] = 1'b1;
            end
            if (r_x >= HX'(BAND1_START) && r_x < h2_x) begin
                nxt_row[1]   = row_reg;
                nxt_found[1] = 1'b1;
            end
            if (!cur_found[2] && r_x >= h2_x && r_x + HX'(BOTTOM_GAP) <= h_x) begin
                nxt_row[2]   = row_reg;
                nxt_found[2] = 1'b1;
            end
            if (r_x > h2_x && r_x + HX'(BOTTOM_GAP) <= h_x) begin
                nxt_row[3]   = row_reg;
                nxt_found[3] = 1'b1;
            end
        end

        fb_y[0] = PT_W'(FIRST_COL);
        fb_y[1] = PT_W'(cur_h >> 1);
        fb_y[2] = PT_W'(cur_h >> 1);
        fb_y[3] = PT_W'(cur_h) - PT_W'(BOTTOM_GAP);

        nsc_sum = (NW+1)'(cur_nsc) + (NW+1)'(cur_step);
        nsc_adv = nsc_sum[NW] ? '1 : nsc_sum[NW-1:0];
    end

    assign out_free = !out_valid_reg
                   || (m_ready && (out_err_reg || out_idx_reg == BAND_LOWER_LAST));
    assign s_ready  = !start_reg && !div_busy && (!emit || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_w_reg  <= '0;
            frame_h_reg  <= '0;
            frame_ok_reg <= 1'b0;
            step_reg     <= '0;
            nsc_reg      <= NW'(FIRST_COL);
            row_reg      <= '0;
            col_reg      <= '0;
            for (int k = 0; k < 4; k++) begin
                band_row_reg[k]   <= '0;
                band_found_reg[k] <= 1'b0;
            end
        end else if (s_xfer) begin
            frame_w_reg  <= cur_w;
            frame_h_reg  <= cur_h;
            frame_ok_reg <= cur_ok;
            step_reg     <= cur_step;
            nsc_reg      <= (col_end && sampled) ? nsc_adv : cur_nsc;
            for (int k = 0; k < 4; k++) begin
                band_row_reg[k]   <= col_end ? '0   : nxt_row[k];
                band_found_reg[k] <= col_end ? 1'b0 : nxt_found[k];
            end
            if (col_end) begin
                row_reg <= '0;
                col_reg <= frame_end ? '0 : col_reg + WW'(1);
            end else begin
                row_reg <= row_reg + HW'(1);
            end
        end
    end

    // result buffer: one column's four points, or the error result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= BAND_UPPER_FIRST;
        end else if (s_xfer && emit) begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= BAND_UPPER_FIRST;
        end else if (m_xfer) begin
            if (out_err_reg || out_idx_reg == BAND_LOWER_LAST) begin
                out_valid_reg <= 1'b0;
            end else begin
                out_idx_reg <= out_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && emit) begin
            out_err_reg <= !sampled;
            out_x_reg   <= sampled ? PT_W'(col_reg) + PT_W'(offset_x_reg) : '0;
            for (int k = 0; k < 4; k++) begin
                out_found_reg[k] <= sampled && nxt_found[k];
                if (!sampled) begin
                    out_y_reg[k] <= '0;
                end else if (nxt_found[k]) begin
                    out_y_reg[k] <= PT_W'(nxt_row[k]) + PT_W'(offset_y_reg);
                end else begin
                    out_y_reg[k] <= fb_y[k] + PT_W'(offset_y_reg);
                end
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_band           = out_err_reg ? BAND_UPPER_FIRST : out_idx_reg;
    assign m_point_x        = out_x_reg;
    assign m_point_y        = out_y_reg[out_idx_reg];
    assign m_found          = out_found_reg[out_idx_reg];
    assign m_last_in_column = out_err_reg || (out_idx_reg == BAND_LOWER_LAST);
    assign m_status         = out_err_reg ? STATUS_BAD_COUNT : STATUS_OK;

    // a column end with a result to send loads the buffer
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && emit) |=> m_valid)
        else $error("result buffer not loaded at column end");

    // the error result carries no point
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_last_in_column && m_band == BAND_UPPER_FIRST
                                   && !m_found && m_point_x == '0 && m_point_y == '0))
        else $error("error result has point fields set");

    // points of a column go out in band order without gaps
    a_band_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && !m_last_in_column) |=> (m_valid && m_band == 2'($past(m_band) + 2'd1)))
        else $error("band sequence broken");

    // no pixel taken while the column step is being derived
    a_no_input_during_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_busy || start_reg) |-> !s_xfer)
        else $error("pixel accepted while step divider busy");

endmodule

@@ dv/cbs_point_checker.sv @@
`timescale 1ns / 1ps

module cbs_point_checker
    import cbs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_is_boundary,

    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [1:0]             m_band,
    input  logic [PT_W-1:0]        m_point_x,
    input  logic [PT_W-1:0]        m_point_y,
    input  logic                   m_found,
    input  logic                   m_last_in_column,
    input  logic                   m_status,

    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        logic [1:0]      band;
        logic [PT_W-1:0] x;
        logic [PT_W-1:0] y;
        logic            found;
        logic            last;
        logic            status;
    } boundary_point_t;

    localparam int PRINT_LIMIT = 40;

    boundary_point_t expected_points[$];

    // register shadows
    logic [DIM_W-1:0] reg_width;
    logic [DIM_W-1:0] reg_height;
    logic [CNT_W-1:0] reg_count;
    logic [OFS_W-1:0] reg_ofs_x;
    logic [OFS_W-1:0] reg_ofs_y;

    int row_pos;
    int col_pos;
    int next_col;
    int col_step;
    int frame_w;
    int frame_h;
    bit frame_ok;
    int band_row[4];
    bit band_found[4];

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [PT_W-1:0] got,
                               input logic [PT_W-1:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic clear_bands();
        int k;
        for (k = 0; k < 4; k++) begin
            band_row[k]   = 0;
            band_found[k] = 1'b0;
        end
    endtask

    // one accepted pixel; queues the points it completes
    task automatic sample_pixel(input logic hit);
        int r;
        int c;
        int half;
        int bottom;
        int n;
        int y;
        int k;
        bit on_col;
        int fallback[4];
        boundary_point_t pt;

        if (row_pos == 0 && col_pos == 0) begin
            frame_w = reg_width;
            if (frame_w > MAX_WIDTH) frame_w = MAX_WIDTH;
            if (frame_w < 1) frame_w = 1;
            frame_h = reg_height;
            if (frame_h > MAX_HEIGHT) frame_h = MAX_HEIGHT;
            if (frame_h < 1) frame_h = 1;
            n = reg_count;
            frame_ok = n >= 2 && n < frame_w - 2 * EDGE_MARGIN;
            col_step = frame_ok ? (frame_w - 2 * EDGE_MARGIN - 1) / (n - 1) : 0;
            next_col = FIRST_COL;
            clear_bands();
        end

        r = row_pos;
        c = col_pos;
        half = frame_h / 2;
        bottom = frame_h - BOTTOM_GAP;
        on_col = frame_ok && c == next_col && c < frame_w - EDGE_MARGIN;

        if (on_col && hit) begin
            if (!band_found[0] && r >= EDGE_MARGIN && r < half) begin
                band_row[0] = r;
                band_found[0] = 1'b1;
            end
            if (r >= BAND1_START && r < half) begin
                band_row[1] = r;
                band_found[1] = 1'b1;
            end
            if (!band_found[2] && r >= half && r <= bottom) begin
                band_row[2] = r;
                band_found[2] = 1'b1;
            end
            if (r > half && r <= bottom) begin
                band_row[3] = r;
                band_found[3] = 1'b1;
            end
        end

        if (r >= frame_h - 1) begin
            if (on_col) begin
                fallback[0] = EDGE_MARGIN;
                fallback[1] = half;
                fallback[2] = half;
                fallback[3] = bottom;
                for (k = 0; k < 4; k++) begin
                    // a negative fallback row wraps within the point width
                    y = band_found[k] ? band_row[k] : fallback[k];
                    pt.band   = 2'(k);
                    pt.x      = PT_W'(c + reg_ofs_x);
                    pt.y      = PT_W'(y + reg_ofs_y);
                    pt.found  = band_found[k];
                    pt.last   = (2'(k) == BAND_LOWER_LAST);
                    pt.status = STATUS_OK;
                    expected_points = {expected_points, pt};
                end
                next_col = next_col + col_step;
                if (next_col > 65535) next_col = 65535;
            end
            clear_bands();
            row_pos = 0;
            if (c >= frame_w - 1) begin
                if (!frame_ok) begin
                    pt        = '0;
                    pt.last   = 1'b1;
                    pt.status = STATUS_BAD_COUNT;
                    expected_points = {expected_points, pt};
                end
                col_pos = 0;
            end else begin
                col_pos++;
            end
        end else begin
            row_pos++;
        end
    endtask

    task automatic check_point();
        boundary_point_t want;
        if (expected_points.size() == 0) begin
            flag_mismatch($sformatf("unexpected point: band %0d x %0d y %0d status %0d",
                                    m_band, m_point_x, m_point_y, m_status));
        end else begin
            want = expected_points.pop_front();
            check_field("band", m_band, want.band);
            check_field("point_x", m_point_x, want.x);
            check_field("point_y", m_point_y, want.y);
            check_field("found", m_found, want.found);
            check_field("last_in_column", m_last_in_column, want.last);
            check_field("status", m_status, want.status);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_width  = RST_IMAGE_WIDTH;
            reg_height = RST_IMAGE_HEIGHT;
            reg_count  = RST_SAMPLE_COUNT;
            reg_ofs_x  = '0;
            reg_ofs_y  = '0;
            row_pos  = 0;
            col_pos  = 0;
            next_col = FIRST_COL;
            col_step = 0;
            frame_w  = 0;
            frame_h  = 0;
            frame_ok = 1'b0;
            clear_bands();
            expected_points.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  reg_width  = cfg_data;
                    REG_IMAGE_HEIGHT: reg_height = cfg_data;
                    REG_SAMPLE_COUNT: reg_count  = cfg_data[CNT_W-1:0];
                    REG_OFFSET_X:     reg_ofs_x  = cfg_data[OFS_W-1:0];
                    REG_OFFSET_Y:     reg_ofs_y  = cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                sample_pixel(s_is_boundary);
            end
            if (m_valid && m_ready) begin
                check_point();
            end
            outstanding <= expected_points.size();
        end
    end

endmodule

@@ dv/tb_column_boundary_sampler.sv @@
`timescale 1ns / 1ps

module tb_column_boundary_sampler;

    import cbs_pkg::*;

    typedef enum int {
        PAT_NONE,
        PAT_ALL,
        PAT_EDGES,
        PAT_SPARSE,
        PAT_HALF,
        PAT_DENSE
    } hit_pattern_t;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic                   s_is_boundary = 1'b0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [1:0]             m_band;
    logic [PT_W-1:0]        m_point_x;
    logic [PT_W-1:0]        m_point_y;
    logic                   m_found;
    logic                   m_last_in_column;
    logic                   m_status;

    int mismatches;
    int outstanding;

    int burst_left   = 0;
    bit no_gaps      = 1'b0;
    int hold_asks    = 0;
    int cfg_w;
    int cfg_h;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    column_boundary_sampler i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_is_boundary    (s_is_boundary),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_band           (m_band),
        .m_point_x        (m_point_x),
        .m_point_y        (m_point_y),
        .m_found          (m_found),
        .m_last_in_column (m_last_in_column),
        .m_status         (m_status)
    );

    cbs_point_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_is_boundary    (s_is_boundary),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_band           (m_band),
        .m_point_x        (m_point_x),
        .m_point_y        (m_point_y),
        .m_found          (m_found),
        .m_last_in_column (m_last_in_column),
        .m_status         (m_status),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // receiver: stretches of steady, patchy or scarce ready, plus one long hold on request
    initial begin : receiver
        int stretch;
        int mode;
        int k;
        int holds_served;
        holds_served = 0;
        forever begin
            stretch = $urandom_range(8, 60);
            mode = $urandom_range(0, 3);
            for (k = 0; k < stretch; k++) begin
                @(posedge aclk);
                if (hold_asks != holds_served) begin
                    holds_served++;
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end
                case (mode)
                    2:       m_ready <= ($urandom_range(0, 3) != 0);
                    3:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic int eff_dim(input int v, input int cap);
        if (v > cap) return cap;
        if (v < 1) return 1;
        return v;
    endfunction

    function automatic logic pick_hit(input hit_pattern_t pat, input int row, input int col,
                                      input int h);
        int half;
        int bottom;
        half = h / 2;
        bottom = h - BOTTOM_GAP;
        case (pat)
            PAT_NONE: return 1'b0;
            PAT_ALL:  return 1'b1;
            // hits on and just outside the band limits
            PAT_EDGES:
                if (col % 2 == 0) begin
                    return row == EDGE_MARGIN - 1 || row == EDGE_MARGIN || row == half - 1
                        || row == half || row == bottom || row == bottom + 1;
                end else begin
                    return row == BAND1_START || row == half + 1;
                end
            PAT_SPARSE: return $urandom_range(0, 7) == 0;
            PAT_HALF:   return $urandom_range(0, 1) == 1;
            default:    return $urandom_range(0, 7) != 0;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // called only with the block idle and every point delivered
    task automatic set_frame(input int w, input int h, input int n, input int ox, input int oy);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(n));
        write_reg(REG_OFFSET_X, CFG_DATA_W'(ox));
        write_reg(REG_OFFSET_Y, CFG_DATA_W'(oy));
        if ($urandom_range(0, 5) == 0) begin
            write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        cfg_w = eff_dim(w % 8192, DEF_MAX_WIDTH);
        cfg_h = eff_dim(h % 8192, DEF_MAX_HEIGHT);
    endtask

    task automatic send_pixel(input logic hit);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!no_gaps) begin
                gap = $urandom_range(0, 5);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_is_boundary <= hit;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_range(input hit_pattern_t pat, input int h, input int first,
                              input int last);
        int idx;
        for (idx = first; idx <= last; idx++) begin
            send_pixel(pick_hit(pat, idx % h, idx / h, h));
        end
    endtask

    // sender pauses until every expected point has arrived
    task automatic wait_results_done();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic play_frame(input hit_pattern_t pat);
        send_range(pat, cfg_h, 0, cfg_w * cfg_h - 1);
        wait_results_done();
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // zero geometry counts as one pixel; count is invalid
        set_frame(0, 0, 0, 0, 0);
        play_frame(PAT_ALL);
        play_frame(PAT_NONE);

        // hits on and just outside the band limits
        set_frame(11, 10, 2, 5, 9);
        play_frame(PAT_EDGES);

        // bottom fallback row goes negative; bit 12 of the offset data is dropped
        set_frame(11, 3, 2, 13'h1FFF, 4095);
        play_frame(PAT_HALF);

        // counts below and past the limits
        set_frame(11, 2, 1, 3, 4);
        play_frame(PAT_HALF);
        set_frame(10, 1, 4095, 6, 7);
        play_frame(PAT_DENSE);

        // registers rewritten mid-frame: offsets at once, geometry at next frame
        set_frame(12, 2, 2, 0, 0);
        send_range(PAT_SPARSE, 2, 0, 11);
        wait_results_done();
        set_frame(11, 3, 2, 100, 200);
        send_range(PAT_DENSE, 2, 12, 23);
        wait_results_done();

        // columns 4 to 15 sampled at step 1 while the receiver holds off
        set_frame(20, 3, 11, 0, 0);
        no_gaps = 1'b1;
        hold_asks <= hold_asks + 1;
        play_frame(PAT_HALF);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
